>>> rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int MAX_ORDER  = 8;
	localparam int POOL_PAGES = 256;
	localparam int PAGE_BYTES = 4096;

	localparam int ORD_W   = $clog2(MAX_ORDER + 1);
	localparam int PAGE_W  = MAX_ORDER;
	localparam int TOP_PAGES = 1 << MAX_ORDER;
	localparam int LINK_W  = PAGE_W + 1;
	localparam int PSH     = $clog2(PAGE_BYTES);
	localparam logic [LINK_W-1:0] NO_PAGE = LINK_W'(TOP_PAGES);
	localparam logic [8:0]  COUNT_MAX = 9'd511;
	localparam logic [15:0] TOTAL_MAX = 16'hFFFF;
	localparam logic [15:0] TOTAL_RST = (POOL_PAGES > 65535) ? 16'hFFFF : 16'(POOL_PAGES);
	localparam logic [32:0] POOL_BYTES = 33'(POOL_PAGES) << PSH;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_COUNT = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_MEM   = 3'd1,
		ST_BAD_ORD  = 3'd2,
		ST_BAD_ADDR = 3'd3,
		ST_NOT_RDY  = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		CFG_POOL_BASE  = 1'd0,
		CFG_POOL_READY = 1'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_TAKE,
		S_SPLIT,
		S_FCHECK,
		S_WALK_RD,
		S_WALK,
		S_UNLINK,
		S_PUT,
		S_DONE
	} state_t;

endpackage

>>> rtl/core/bpa_if.sv
// ----------------------------------------------------------------------------
// bpa_req_if / bpa_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface bpa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [4:0]  block_order;
	logic [31:0] block_address;
	modport source(output valid, operation, block_order, block_address, input ready);
	modport sink(input valid, operation, block_order, block_address, output ready);
endinterface

interface bpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] result_address;
	logic [15:0] free_page_cnt;
	logic [8:0]  order_block_count;
	modport source(output valid, status, result_address, free_page_cnt, order_block_count,
		input ready);
	modport sink(input valid, status, result_address, free_page_cnt, order_block_count,
		output ready);
endinterface

>>> rtl/core/buddy_page_allocator_top.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// Buddy allocator with per-order LIFO free lists held in a link memory.
// ----------------------------------------------------------------------------
// channel   dir  handshake     payload
// req       in   valid/ready   operation, block_order, block_address
// rsp       out  valid/ready   status, result_address, free_page_cnt, order_block_count
// cfg       in   we only       cfg_index, cfg_data
//
// one request at a time; a sequencer steps the link memory, one read or write
// a cycle. allocate: a search step per order tried (up to MAX_ORDER+1 orders),
// a take step, a split step per order split off, then a done step. free: a check
// step, then per merge level a read and a walk step per block walked, a put and done.
// the result register holds until taken; req is not ready meanwhile.
// reset clears lists to one top-order block at page 0.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top
	import bpa_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	bpa_req_if.sink      req,
	bpa_rsp_if.source    rsp
);

	logic [31:0] pool_base_q;
	logic        pool_ready_q;
	logic [LINK_W-1:0] head_q [MAX_ORDER+1];
	logic [8:0]        cnt_q  [MAX_ORDER+1];
	logic [15:0]       total_q;
	logic [LINK_W-1:0] link_mem [TOP_PAGES];
	logic [LINK_W-1:0] rd_q;
	logic              link0_set_q;

	state_t state_q, state_d;
	logic [4:0]        ord_q;     // requested order
	logic [ORD_W-1:0]  cur_q;     // working order
	logic [PAGE_W-1:0] page_q;
	logic [LINK_W-1:0] walk_q, prev_q;
	logic [8:0]        steps_q;
	logic [31:0]       addr_q;
	logic [2:0]        st_q;
	logic              rsp_v_q;

	// memory port controls
	logic              mw_en, mr_en;
	logic [PAGE_W-1:0] mw_addr, mr_addr;
	logic [LINK_W-1:0] mw_data;

	logic [PAGE_W-1:0] buddy;
	logic [32:0]       off;
	logic              addr_bad;

	assign buddy = page_q ^ PAGE_W'(1 << cur_q);
	assign off   = {1'b0, req.block_address} - {1'b0, pool_base_q};
	always_comb begin
		addr_bad = (req.block_address == 32'd0) || off[32] || (off >= POOL_BYTES);
		if ((off & ((33'(PAGE_BYTES) << req.block_order[ORD_W-1:0]) - 33'd1)) != 33'd0)
			addr_bad = 1'b1;
		if ((off >> PSH) >= 33'(TOP_PAGES))
			addr_bad = 1'b1;
	end

	assign req.ready = (state_q == S_IDLE) && !rsp_v_q;
	assign rsp.valid = rsp_v_q;
	assign rsp.status = st_q;
	assign rsp.result_address = addr_q;
	assign rsp.free_page_cnt = total_q;
	assign rsp.order_block_count = (ord_q <= 5'(MAX_ORDER)) ? cnt_q[ord_q[ORD_W-1:0]] : 9'd0;

	always_ff @(posedge clk) begin
		if (mw_en)
			link_mem[mw_addr] <= mw_data;
		// link of page 0 reads as empty until first written
		if (mr_en)
			rd_q <= (mr_addr == '0 && !link0_set_q) ? NO_PAGE : link_mem[mr_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			link0_set_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mw_en && mw_addr == '0)
				link0_set_q <= 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		mw_en = 1'b0; mr_en = 1'b0;
		mw_addr = page_q; mr_addr = page_q; mw_data = NO_PAGE;
		case (state_q)
			S_IDLE: begin
				if (req.valid && req.ready) begin
					if (!pool_ready_q || req.block_order > 5'(MAX_ORDER))
						state_d = S_DONE;
					else if (req.operation == OP_ALLOC)
						state_d = S_SEARCH;
					else if (req.operation == OP_FREE)
						state_d = S_FCHECK;
					else
						state_d = S_DONE;
				end
			end
			S_SEARCH: begin
				if (head_q[cur_q] != NO_PAGE) begin
					state_d = S_TAKE;
					mr_en = 1'b1;
					mr_addr = head_q[cur_q][PAGE_W-1:0];
				end else if (cur_q == ORD_W'(MAX_ORDER))
					state_d = S_DONE;
			end
			S_TAKE: state_d = (cur_q == ord_q[ORD_W-1:0]) ? S_DONE : S_SPLIT;
			S_SPLIT: begin
				mw_en = 1'b1;
				mw_addr = page_q | PAGE_W'(1 << (cur_q - 1'b1));
				mw_data = head_q[cur_q - 1'b1];
				if (cur_q - 1'b1 == ord_q[ORD_W-1:0])
					state_d = S_DONE;
			end
			S_FCHECK: begin
				if (st_q != ST_OK)
					state_d = S_DONE;
				else
					state_d = (cur_q == ORD_W'(MAX_ORDER)) ? S_PUT : S_WALK_RD;
			end
			S_WALK_RD: begin
				if (walk_q[LINK_W-1] || steps_q >= cnt_q[cur_q])
					state_d = S_PUT;
				else begin
					mr_en = 1'b1;
					mr_addr = walk_q[PAGE_W-1:0];
					state_d = (walk_q[PAGE_W-1:0] == buddy) ? S_UNLINK : S_WALK;
				end
			end
			S_WALK: state_d = S_WALK_RD;
			S_UNLINK: begin
				if (!prev_q[LINK_W-1]) begin
					mw_en = 1'b1;
					mw_addr = prev_q[PAGE_W-1:0];
					mw_data = rd_q;
				end
				state_d = (cur_q + 1'b1 == ORD_W'(MAX_ORDER)) ? S_PUT : S_WALK_RD;
			end
			S_PUT: begin
				mw_en = 1'b1;
				mw_data = head_q[cur_q];
				state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			pool_ready_q <= 1'b1;
			for (int i = 0; i <= MAX_ORDER; i++) begin
				head_q[i] <= (i == MAX_ORDER) ? LINK_W'(0) : NO_PAGE;
				cnt_q[i]  <= (i == MAX_ORDER) ? 9'd1 : 9'd0;
			end
			total_q <= TOTAL_RST;
			rsp_v_q <= 1'b0;
			ord_q <= '0; cur_q <= '0; page_q <= '0; walk_q <= NO_PAGE; prev_q <= NO_PAGE;
			steps_q <= '0; addr_q <= '0; st_q <= ST_OK;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_POOL_BASE:  pool_base_q <= cfg_data;
					CFG_POOL_READY: pool_ready_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (rsp_v_q && rsp.ready)
				rsp_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						ord_q <= req.block_order;
						cur_q <= req.block_order[ORD_W-1:0];
						addr_q <= '0;
						st_q <= ST_OK;
						page_q <= off[PSH +: PAGE_W];
						if (!pool_ready_q)
							st_q <= ST_NOT_RDY;
						else if (req.block_order > 5'(MAX_ORDER))
							st_q <= ST_BAD_ORD;
						else if (req.operation == OP_FREE) begin
							if (addr_bad)
								st_q <= ST_BAD_ADDR;
						end
					end
				end
				S_SEARCH: begin
					if (head_q[cur_q] != NO_PAGE) begin
						page_q <= head_q[cur_q][PAGE_W-1:0];
						if (cnt_q[cur_q] != 9'd0)
							cnt_q[cur_q] <= cnt_q[cur_q] - 9'd1;
						total_q <= (total_q > 16'(1 << ord_q)) ?
							total_q - 16'(1 << ord_q) : 16'd0;
					end else if (cur_q == ORD_W'(MAX_ORDER))
						st_q <= ST_NO_MEM;
					else
						cur_q <= cur_q + 1'b1;
				end
				S_TAKE: begin
					head_q[cur_q] <= rd_q;
					addr_q <= pool_base_q + 32'({page_q, PSH'(0)});
				end
				S_SPLIT: begin
					head_q[cur_q - 1'b1] <= {1'b0, page_q | PAGE_W'(1 << (cur_q - 1'b1))};
					if (cnt_q[cur_q - 1'b1] != COUNT_MAX)
						cnt_q[cur_q - 1'b1] <= cnt_q[cur_q - 1'b1] + 9'd1;
					cur_q <= cur_q - 1'b1;
				end
				S_FCHECK: begin
					if (st_q == ST_OK) begin
						total_q <= (17'(total_q) + 17'(1 << cur_q) > 17'(TOTAL_MAX)) ?
							TOTAL_MAX : total_q + 16'(1 << cur_q);
						walk_q <= head_q[cur_q];
						prev_q <= NO_PAGE;
						steps_q <= '0;
					end
				end
				S_WALK: begin
					prev_q <= walk_q;
					walk_q <= rd_q;
					steps_q <= steps_q + 9'd1;
				end
				S_UNLINK: begin
					if (prev_q[LINK_W-1])
						head_q[cur_q] <= rd_q;
					cnt_q[cur_q] <= cnt_q[cur_q] - 9'd1;
					page_q <= page_q & ~PAGE_W'(1 << cur_q);
					cur_q <= cur_q + 1'b1;
					walk_q <= head_q[cur_q + 1'b1];
					prev_q <= NO_PAGE;
					steps_q <= '0;
				end
				S_PUT: begin
					head_q[cur_q] <= {1'b0, page_q};
					if (cnt_q[cur_q] != COUNT_MAX)
						cnt_q[cur_q] <= cnt_q[cur_q] + 9'd1;
				end
				S_DONE: rsp_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

endmodule

>>> tb/buddy_page_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_top_tb
// Self-checking bench: a scoreboard keeps its own copy of the free lists,
// predicts every result from the accepted requests and compares each field.
// Requests follow allocate/free traffic on tracked blocks, plus malformed noise.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top_tb;
	import bpa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t     st;
		logic [31:0] addr;
		logic [15:0] pages;
		logic [8:0]  blocks;
	} alloc_result_t;

	class alloc_scoreboard;
		bit [31:0] base;
		bit        ready;
		bit [8:0]  head [0:MAX_ORDER];
		bit [8:0]  link [0:TOP_PAGES-1];
		bit [8:0]  cnt [0:MAX_ORDER];
		bit [15:0] total;
		alloc_result_t pending[$];
		int errors;

		function new();
			base = 0;
			ready = 1;
			for (int i = 0; i <= MAX_ORDER; i++) begin
				head[i] = NO_PAGE;
				cnt[i] = 0;
			end
			link[0] = NO_PAGE;
			head[MAX_ORDER] = 0;
			cnt[MAX_ORDER] = 1;
			total = TOTAL_RST;
			errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, bit [31:0] value);
			if (idx == CFG_POOL_BASE)
				base = value;
			else
				ready = value[0];
		endfunction

		function void list_push(int o, bit [8:0] page);
			link[page] = head[o];
			head[o] = page;
			if (cnt[o] < COUNT_MAX)
				cnt[o]++;
		endfunction

		function bit unlink_block(int o, bit [8:0] page);
			bit [8:0] prev;
			bit [8:0] cur;
			int steps;
			prev = NO_PAGE;
			cur = head[o];
			steps = 0;
			while (cur < TOP_PAGES && steps < cnt[o]) begin
				if (cur == page) begin
					if (prev < TOP_PAGES)
						link[prev] = link[cur];
					else
						head[o] = link[cur];
					cnt[o]--;
					return 1;
				end
				prev = cur;
				cur = link[cur];
				steps++;
			end
			return 0;
		endfunction

		function status_t allocate(int o, output bit [31:0] addr);
			int cur;
			bit [8:0] page;
			cur = o;
			addr = 0;
			while (cur <= MAX_ORDER && head[cur] >= TOP_PAGES)
				cur++;
			if (cur > MAX_ORDER)
				return ST_NO_MEM;
			page = head[cur];
			head[cur] = link[page];
			if (cnt[cur] > 0)
				cnt[cur]--;
			while (cur > o) begin
				cur--;
				list_push(cur, page + (9'd1 << cur));
			end
			total = (total > (16'd1 << o)) ? total - (16'd1 << o) : 16'd0;
			addr = base + 32'(page) * PAGE_BYTES;
			return ST_OK;
		endfunction

		function status_t release_block(int o, bit [31:0] a);
			bit [63:0] off;
			bit [63:0] lim;
			bit [8:0] page;
			int t;
			lim = 64'(base) + 64'(POOL_PAGES) * PAGE_BYTES;
			if (a == 0 || a < base || 64'(a) >= lim)
				return ST_BAD_ADDR;
			off = 64'(a) - 64'(base);
			if (off % (64'(PAGE_BYTES) << o) != 0)
				return ST_BAD_ADDR;
			if (off / PAGE_BYTES >= TOP_PAGES)
				return ST_BAD_ADDR;
			page = 9'(off / PAGE_BYTES);
			t = int'(total) + (1 << o);
			total = (t > 65535) ? TOTAL_MAX : 16'(t);
			while (o < MAX_ORDER) begin
				if (!unlink_block(o, page ^ (9'd1 << o)))
					break;
				page &= ~(9'd1 << o);
				o++;
			end
			list_push(o, page);
			return ST_OK;
		endfunction

		// predicts the result of an accepted request and queues it
		function alloc_result_t note_request(bit [1:0] op, bit [4:0] o, bit [31:0] a);
			alloc_result_t r;
			bit [31:0] addr;
			addr = 0;
			r.st = ST_OK;
			if (!ready)
				r.st = ST_NOT_RDY;
			else if (o > MAX_ORDER)
				r.st = ST_BAD_ORD;
			else if (op == OP_ALLOC)
				r.st = allocate(o, addr);
			else if (op == OP_FREE)
				r.st = release_block(o, a);
			r.addr = addr;
			r.pages = total;
			r.blocks = (o <= MAX_ORDER) ? cnt[o] : 9'd0;
			pending.push_back(r);
			return r;
		endfunction

		function void check_result(logic [2:0] st, logic [31:0] addr, logic [15:0] pages,
			logic [8:0] blocks);
			alloc_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result transaction: status %0d", st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.st) begin
				$error("status: expected %0d, actual %0d", e.st, st);
				errors++;
			end
			if (addr !== e.addr) begin
				$error("result_address: expected %h, actual %h", e.addr, addr);
				errors++;
			end
			if (pages !== e.pages) begin
				$error("free_page_cnt: expected %0d, actual %0d", e.pages, pages);
				errors++;
			end
			if (blocks !== e.blocks) begin
				$error("order_block_count: expected %0d, actual %0d", e.blocks, blocks);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;

	bpa_req_if req_ch();
	bpa_rsp_if rsp_ch();

	buddy_page_allocator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	alloc_scoreboard sb = new();
	bit        quiet;
	int        hold_off;
	bit [7:0]  live_page[$];
	bit [3:0]  live_ord[$];

	initial clk = 0;
	always #6 clk = ~clk;

	initial begin
		#50ms;
		$display("buddy_page_allocator_top verification failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// receiver side: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				rsp_ch.ready = 0;
				hold_off--;
			end else if (stall > 0) begin
				rsp_ch.ready = 0;
				stall--;
			end else begin
				rsp_ch.ready = 1;
				if ($urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
		end
	end

	always @(posedge clk)
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result(rsp_ch.status, rsp_ch.result_address, rsp_ch.free_page_cnt,
				rsp_ch.order_block_count);

	// called at a falling edge, returns at a falling edge
	task automatic send_req(bit [1:0] op, bit [4:0] o, bit [31:0] a);
		alloc_result_t r;
		int gap;
		req_ch.valid = 1;
		req_ch.operation = op;
		req_ch.block_order = o;
		req_ch.block_address = a;
		do @(posedge clk); while (!req_ch.ready);
		r = sb.note_request(op, o, a);
		if (op == OP_ALLOC && r.st == ST_OK) begin
			live_page.push_back(8'((r.addr - sb.base) >> PSH));
			live_ord.push_back(4'(o));
		end
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid = 0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic free_live(int i, bit keep);
		bit [7:0] p;
		bit [3:0] o;
		p = live_page[i];
		o = live_ord[i];
		if (!keep) begin
			live_page.delete(i);
			live_ord.delete(i);
		end
		send_req(OP_FREE, 5'(o), sb.base + 32'(p) * PAGE_BYTES);
	endtask

	task automatic wait_idle();
		req_ch.valid = 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, bit [31:0] value);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = value;
		sb.set_reg(idx, value);
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic random_traffic(int n);
		int r;
		for (int k = 0; k < n; k++) begin
			if (k % 100 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 85 && r >= 45 && live_page.size() > 0)
				free_live($urandom_range(0, live_page.size() - 1), 0);
			else if (r < 85)
				send_req(OP_ALLOC, ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3)
					: $urandom_range(0, MAX_ORDER), $urandom);
			else if (r < 90)
				send_req($urandom_range(2, 3), $urandom_range(0, 31), $urandom);
			else if (r < 95)
				send_req(OP_FREE, $urandom_range(0, 31), ($urandom_range(0, 1) ?
					$urandom : sb.base + ($urandom_range(0, 1023) << 10)));
			else
				send_req($urandom_range(0, 3), $urandom_range(MAX_ORDER + 1, 31), $urandom);
		end
		quiet = 0;
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_POOL_BASE;
		cfg_data = 0;
		req_ch.valid = 0;
		req_ch.operation = OP_ALLOC;
		req_ch.block_order = 0;
		req_ch.block_address = 0;
		quiet = 0;
		hold_off = 0;
		repeat (12) @(negedge clk);
		arst_n = 1;
		repeat (2) @(negedge clk);

		// directed: extremes, each operation and the failure paths
		write_reg(CFG_POOL_BASE, 32'h0);
		write_reg(CFG_POOL_READY, 1);
		send_req(OP_COUNT, MAX_ORDER, 0);
		send_req(OP_ALLOC, 0, 0);
		send_req(OP_ALLOC, MAX_ORDER, 0);
		send_req(OP_ALLOC, MAX_ORDER + 1, 0);
		send_req(OP_ALLOC, 31, 32'hFFFF_FFFF);
		send_req(2'd3, 2, 0);
		send_req(OP_FREE, 0, 32'h0);
		send_req(OP_FREE, 0, 32'h0010_0000);
		send_req(OP_FREE, 0, 32'hFFFF_FFFF);
		send_req(OP_FREE, 1, 32'h0000_1000);
		send_req(OP_FREE, 0, 32'h0000_0800);
		send_req(OP_FREE, MAX_ORDER + 1, 32'h0000_1000);
		send_req(OP_ALLOC, 3, 0);
		send_req(OP_ALLOC, 0, 0);
		free_live(0, 0);
		free_live(0, 0);
		free_live(0, 0);
		send_req(OP_ALLOC, MAX_ORDER, 0);
		free_live(0, 0);
		// double free is not caught: the count keeps growing
		send_req(OP_ALLOC, 0, 0);
		free_live(0, 1);
		free_live(0, 0);
		send_req(OP_COUNT, 0, 0);

		fork
			random_traffic(400);
			begin
				repeat (500) @(negedge clk);
				hold_off = 300;
			end
		join
		wait_idle();

		write_reg(CFG_POOL_BASE, 32'hFFF0_0000);
		random_traffic(300);
		wait_idle();

		write_reg(CFG_POOL_READY, 0);
		random_traffic(30);
		wait_idle();

		write_reg(CFG_POOL_READY, 1);
		write_reg(CFG_POOL_BASE, {12'($urandom_range(1, 4094)), 20'h0});
		random_traffic(200);
		wait_idle();

		// base off the pool alignment
		write_reg(CFG_POOL_BASE, $urandom);
		random_traffic(100);
		wait_idle();

		if (sb.errors == 0)
			$display("buddy_page_allocator_top verification clean");
		else
			$display("buddy_page_allocator_top verification failed");
		$finish;
	end

endmodule
